/* rtl/torq_pkg.sv */
// Shared types, codes and constants of the timestamp-ordered request queue.
package torq_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int PRIO_W = 16;
	localparam int SRC_W = 8;
	localparam int KIND_W = 2;
	localparam int STATUS_W = 2;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	// Sort key: timestamp first, then source id; packed so a vector compare orders it.
	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [SRC_W-1:0] src;
	} entry_t;

	// Broadcast to every cell in the update cycle.
	typedef struct packed {
		logic ins;
		logic rem;
		entry_t new_entry;
	} cell_ctrl_t;

endpackage

/* rtl/torq_cell.sv */
// One slot of the sorted queue: compare against the new key and shift.
module torq_cell (
	input logic clk,
	input torq_pkg::cell_ctrl_t ctrl,
	input logic occupied,
	input logic left_after,
	input torq_pkg::entry_t left_entry,
	input torq_pkg::entry_t right_entry,
	output logic after,
	output torq_pkg::entry_t entry
);

	torq_pkg::entry_t entry_q;

	// Slot lies past the insert point: empty, or holds a strictly larger key.
	assign after = !occupied || (entry_q > ctrl.new_entry);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins && after) begin
			entry_q <= left_after ? left_entry : ctrl.new_entry;
		end else if (ctrl.rem) begin
			entry_q <= right_entry;
		end
	end

endmodule

/* rtl/timestamp_ordered_request_queue.sv */
// Top level of the timestamp-ordered request queue: request sequencer and cell row.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------
//  request | in        | req_valid / req_ready | kind, priority_req, source_id
//  result  | out       | rsp_valid / rsp_ready | status, head_valid, head_priority,
//          |           |                       | head_source, source_at_top, entry_count
//
// A request is latched on acceptance; when it is applied, every cell of the row
// compares its key with the new one and shifts in parallel, so the whole row
// settles at one edge and the result is posted at that same edge.
// The next request is accepted once the previous one is applied, even while its
// result still waits; a latched request is applied only once the slot holding the
// result is free, so the row and count hold while a result is stalled.
// Reset empties the queue at once (the count clears); cell contents are left
// as they are and are only read below the count.
module timestamp_ordered_request_queue #(
	parameter int QUEUE_DEPTH = torq_pkg::DEPTH_DEFAULT,
	parameter int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
	input logic clk,
	input logic arst_n,

	input logic req_valid,
	output logic req_ready,
	input logic [torq_pkg::KIND_W-1:0] kind,
	input logic [torq_pkg::PRIO_W-1:0] priority_req,
	input logic [torq_pkg::SRC_W-1:0] source_id,

	output logic rsp_valid,
	input logic rsp_ready,
	output logic [torq_pkg::STATUS_W-1:0] status,
	output logic head_valid,
	output logic [torq_pkg::PRIO_W-1:0] head_priority,
	output logic [torq_pkg::SRC_W-1:0] head_source,
	output logic source_at_top,
	output logic [CNT_W-1:0] entry_count
);

	// Sequencer: busy_q holds a latched request, rsp_valid_q a finished result.
	logic busy_q;
	logic rsp_valid_q;
	logic [torq_pkg::KIND_W-1:0] kind_q;
	torq_pkg::entry_t req_q;
	logic [torq_pkg::STATUS_W-1:0] status_q;
	logic [torq_pkg::SRC_W-1:0] rsp_src_q;
	logic [CNT_W-1:0] count_q;

	logic is_full;
	logic is_empty;
	logic retire;
	logic do_ins;
	logic do_rem;
	torq_pkg::cell_ctrl_t ctrl;

	torq_pkg::entry_t cell_entry [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] cell_after;

	assign req_ready = !busy_q;
	// Latched request is applied when the result slot is empty or being emptied.
	assign retire = busy_q && (!rsp_valid_q || rsp_ready);
	assign is_full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign is_empty = (count_q == '0);
	assign do_ins = retire && (kind_q == torq_pkg::KIND_INSERT) && !is_full;
	assign do_rem = retire && (kind_q == torq_pkg::KIND_REMOVE) && !is_empty;

	assign ctrl.ins = do_ins;
	assign ctrl.rem = do_rem;
	assign ctrl.new_entry = req_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (req_valid && req_ready) begin
				busy_q <= 1'b1;
			end else if (retire) begin
				busy_q <= 1'b0;
			end
			if (retire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (do_ins) begin
				count_q <= count_q + 1'b1;
			end else if (do_rem) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Request and result payload, no reset needed.
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			kind_q <= kind;
			req_q.prio <= priority_req;
			req_q.src <= source_id;
		end
		if (retire) begin
			rsp_src_q <= req_q.src;
			case (kind_q)
				torq_pkg::KIND_INSERT: status_q <= is_full ? torq_pkg::STATUS_FULL
					: torq_pkg::STATUS_DONE;
				torq_pkg::KIND_REMOVE: status_q <= is_empty ? torq_pkg::STATUS_EMPTY
					: torq_pkg::STATUS_DONE;
				default: status_q <= torq_pkg::STATUS_DONE;
			endcase
		end
	end

	// Row of cells, head at index 0. An insert shifts every slot past the
	// insert point one to the right; a remove shifts the whole row left.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic occupied;
		logic left_after;
		torq_pkg::entry_t left_entry;
		torq_pkg::entry_t right_entry;

		assign occupied = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign left_after = 1'b0;
			assign left_entry = req_q;
		end else begin : g_mid
			assign left_after = cell_after[i-1];
			assign left_entry = cell_entry[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign right_entry = cell_entry[i];
		end else begin : g_inner
			assign right_entry = cell_entry[i+1];
		end

		torq_cell u_cell (
			.clk(clk),
			.ctrl(ctrl),
			.occupied(occupied),
			.left_after(left_after),
			.left_entry(left_entry),
			.right_entry(right_entry),
			.after(cell_after[i]),
			.entry(cell_entry[i])
		);
	end

	// Result reads the head cell and count, both frozen while the result waits;
	// the asked source is kept apart since the next request may already be latched.
	assign rsp_valid = rsp_valid_q;
	assign status = status_q;
	assign head_valid = !is_empty;
	assign head_priority = is_empty ? '0 : cell_entry[0].prio;
	assign head_source = is_empty ? '0 : cell_entry[0].src;
	assign source_at_top = !is_empty && (cell_entry[0].src == rsp_src_q);
	assign entry_count = count_q;

endmodule

/* bench/tb_timestamp_ordered_request_queue.sv */
// Testbench for the timestamp-ordered request queue: directed and random requests, scoreboarded.
module tb_timestamp_ordered_request_queue;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	// Kind code the block treats as a query.
	localparam logic [torq_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 500000;
	localparam int MAX_PRINTS = 40;

	// Everything the block reports back for one request.
	typedef struct {
		logic [torq_pkg::STATUS_W-1:0] status;
		logic head_valid;
		logic [torq_pkg::PRIO_W-1:0] head_priority;
		logic [torq_pkg::SRC_W-1:0] head_source;
		logic source_at_top;
		logic [CNT_W-1:0] entry_count;
	} head_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	logic [torq_pkg::KIND_W-1:0] kind = torq_pkg::KIND_QUERY;
	logic [torq_pkg::PRIO_W-1:0] priority_req = '0;
	logic [torq_pkg::SRC_W-1:0] source_id = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	logic [torq_pkg::STATUS_W-1:0] status;
	logic head_valid;
	logic [torq_pkg::PRIO_W-1:0] head_priority;
	logic [torq_pkg::SRC_W-1:0] head_source;
	logic source_at_top;
	logic [CNT_W-1:0] entry_count;

	// Shadow copy of the sorted queue, head at index 0.
	torq_pkg::entry_t shadow_q [DEPTH];
	int shadow_count = 0;
	head_report_t pending_heads [$];

	int mismatch_count = 0;
	int cycle_count = 0;
	int req_gap_pct = 0;
	int rsp_stall_pct = 0;

	timestamp_ordered_request_queue #(
		.QUEUE_DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.kind(kind),
		.priority_req(priority_req),
		.source_id(source_id),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.status(status),
		.head_valid(head_valid),
		.head_priority(head_priority),
		.head_source(head_source),
		.source_at_top(source_at_top),
		.entry_count(entry_count)
	);

	always #1 clk = ~clk;

	// Result-side backpressure: ready drops at random at the current stall rate.
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_timestamp_ordered_request_queue: FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS)
			$display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	// Applies one request to the shadow queue and returns the head report it should produce.
	// Inserts go after every entry whose (timestamp, source) key is not larger.
	function automatic head_report_t apply_request(input logic [torq_pkg::KIND_W-1:0] k,
			input logic [torq_pkg::PRIO_W-1:0] p, input logic [torq_pkg::SRC_W-1:0] s);
		head_report_t r;
		int pos;
		r.status = torq_pkg::STATUS_DONE;
		if (k == torq_pkg::KIND_INSERT) begin
			if (shadow_count >= DEPTH) begin
				r.status = torq_pkg::STATUS_FULL;
			end else begin
				pos = 0;
				while (pos < shadow_count && {shadow_q[pos].prio, shadow_q[pos].src} <= {p, s})
					pos++;
				for (int i = shadow_count; i > pos; i--)
					shadow_q[i] = shadow_q[i - 1];
				shadow_q[pos].prio = p;
				shadow_q[pos].src = s;
				shadow_count++;
			end
		end else if (k == torq_pkg::KIND_REMOVE) begin
			if (shadow_count == 0) begin
				r.status = torq_pkg::STATUS_EMPTY;
			end else begin
				for (int i = 0; i + 1 < shadow_count; i++)
					shadow_q[i] = shadow_q[i + 1];
				shadow_count--;
			end
		end
		// Query and the spare kind leave the queue alone.
		if (shadow_count > 0) begin
			r.head_valid = 1'b1;
			r.head_priority = shadow_q[0].prio;
			r.head_source = shadow_q[0].src;
			r.source_at_top = (shadow_q[0].src == s);
		end else begin
			r.head_valid = 1'b0;
			r.head_priority = '0;
			r.head_source = '0;
			r.source_at_top = 1'b0;
		end
		r.entry_count = shadow_count[CNT_W-1:0];
		return r;
	endfunction

	// Sends one request, idling first at the current gap rate. Valid is only lowered
	// when a gap is taken, so back-to-back requests keep it high.
	task automatic send_request(input logic [torq_pkg::KIND_W-1:0] k,
			input logic [torq_pkg::PRIO_W-1:0] p, input logic [torq_pkg::SRC_W-1:0] s);
		if ($urandom_range(99) < req_gap_pct) begin
			req_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < req_gap_pct);
		end
		req_valid <= 1'b1;
		kind <= k;
		priority_req <= p;
		source_id <= s;
		do
			@(posedge clk);
		while (!req_ready);
		pending_heads.push_back(apply_request(k, p, s));
	endtask

	// Every accepted result is checked against the oldest outstanding prediction.
	always @(posedge clk) begin : check_result
		head_report_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_heads.size() == 0) begin
				report_mismatch("result with no request outstanding", status, 0);
			end else begin
				want = pending_heads.pop_front();
				if (status !== want.status)
					report_mismatch("status", status, want.status);
				if (head_valid !== want.head_valid)
					report_mismatch("head_valid", head_valid, want.head_valid);
				if (head_priority !== want.head_priority)
					report_mismatch("head_priority", head_priority, want.head_priority);
				if (head_source !== want.head_source)
					report_mismatch("head_source", head_source, want.head_source);
				if (source_at_top !== want.source_at_top)
					report_mismatch("source_at_top", source_at_top, want.source_at_top);
				if (entry_count !== want.entry_count)
					report_mismatch("entry_count", entry_count, want.entry_count);
			end
		end
	end

	// Empty queue: remove underflows, query and spare kind report an all-zero head
	// even when the asked source is zero.
	task automatic test_empty_queue();
		send_request(torq_pkg::KIND_REMOVE, 16'hFFFF, 8'h00);
		send_request(torq_pkg::KIND_QUERY, 16'h0000, 8'h00);
		send_request(KIND_SPARE, 16'hFFFF, 8'hFF);
	endtask

	// Fill to capacity with extreme and tied keys, then one insert past full.
	task automatic test_fill_to_overflow();
		send_request(torq_pkg::KIND_INSERT, 16'hFFFF, 8'hFF);
		send_request(torq_pkg::KIND_INSERT, 16'h0000, 8'h00);
		send_request(torq_pkg::KIND_INSERT, 16'h1234, 8'h55);
		send_request(torq_pkg::KIND_INSERT, 16'h1234, 8'h55);
		send_request(torq_pkg::KIND_INSERT, 16'h1234, 8'h54);
		send_request(torq_pkg::KIND_INSERT, 16'h1234, 8'h56);
		send_request(torq_pkg::KIND_INSERT, 16'h0000, 8'hFF);
		send_request(torq_pkg::KIND_INSERT, 16'hFFFF, 8'h00);
		repeat (8)
			send_request(torq_pkg::KIND_INSERT, 16'($urandom_range(15)),
				8'($urandom_range(3)));
		send_request(torq_pkg::KIND_INSERT, 16'h0000, 8'h00);
	endtask

	// Head ownership on a full queue, then pop two.
	task automatic test_head_queries();
		send_request(torq_pkg::KIND_QUERY, 16'hFFFF, shadow_q[0].src);
		send_request(torq_pkg::KIND_QUERY, 16'h0000, ~shadow_q[0].src);
		send_request(KIND_SPARE, 16'h0000, shadow_q[0].src);
		send_request(torq_pkg::KIND_REMOVE, 16'h0000, 8'hFF);
		send_request(torq_pkg::KIND_REMOVE, 16'hFFFF, shadow_q[0].src);
	endtask

	// Random traffic that swings between filling and draining so the count crosses
	// its whole range, full and empty included. Narrow key ranges force many ties.
	task automatic test_random_traffic(input int n_requests, input int gap_pct,
			input int stall_pct);
		bit filling;
		int r;
		int insert_share;
		logic [torq_pkg::KIND_W-1:0] k;
		logic [torq_pkg::PRIO_W-1:0] p;
		logic [torq_pkg::SRC_W-1:0] s;
		req_gap_pct = gap_pct;
		rsp_stall_pct = stall_pct;
		filling = (shadow_count < DEPTH / 2);
		repeat (n_requests) begin
			if (shadow_count >= DEPTH)
				filling = 1'b0;
			else if (shadow_count == 0)
				filling = 1'b1;
			insert_share = filling ? 60 : 25;
			r = $urandom_range(99);
			if (r < 3)
				k = KIND_SPARE;
			else if (r < 15)
				k = torq_pkg::KIND_QUERY;
			else if (r < 15 + insert_share)
				k = torq_pkg::KIND_INSERT;
			else
				k = torq_pkg::KIND_REMOVE;
			case ($urandom_range(3))
				0: p = 16'($urandom_range(7));
				2: p = $urandom_range(1) ? 16'hFFFF - 16'($urandom_range(3))
					: 16'($urandom_range(3));
				default: p = 16'($urandom);
			endcase
			s = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom);
			// Queries mostly ask about the current head owner.
			if (k != torq_pkg::KIND_INSERT && shadow_count > 0 && $urandom_range(99) < 60)
				s = shadow_q[0].src;
			send_request(k, p, s);
		end
	endtask

	// Stop sending and wait for every outstanding result.
	task automatic wait_until_idle();
		req_valid <= 1'b0;
		while (pending_heads.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		req_gap_pct = 23;
		rsp_stall_pct = 82;
		test_empty_queue();
		test_fill_to_overflow();
		test_head_queries();
		test_random_traffic(475, 23, 82);
		test_random_traffic(475, 82, 23);
		test_random_traffic(475, 0, 0);
		wait_until_idle();

		// Keep the clock running to catch any stray result.
		repeat (8)
			@(posedge clk);
		if (pending_heads.size() != 0)
			report_mismatch("requests left without a result", pending_heads.size(), 0);
		if (mismatch_count == 0) begin
			$display("tb_timestamp_ordered_request_queue: PASS");
		end else begin
			$display("tb_timestamp_ordered_request_queue: FAIL");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/torq_pkg.sv
rtl/torq_cell.sv
rtl/timestamp_ordered_request_queue.sv
bench/tb_timestamp_ordered_request_queue.sv
